// ----- src/keyed_slot_allocator_top_assert.svh -----
`ifndef KEYED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define KEYED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
// Assertion checked on every clock edge outside reset.
`define KSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Assertion checked on every clock edge, reset included.
`define KSA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/ksa_pkg.sv -----
package ksa_pkg;
	localparam int MAX_SLOTS_DEF = 1024;
	localparam int KEY_BITS_DEF  = 64;

	localparam int OP_W     = 2;
	localparam int KEYIN_W  = 64;
	localparam int LEN_W    = 25;
	localparam int STAT_W   = 3;
	localparam int SLOTID_W = 10;
	localparam int OFF_W    = 34;
	localparam int USED_W   = 11;
	localparam int BYTES_W  = 35;
	localparam int CFG_W    = 25;
	localparam int TOTAL_W  = 11;
	localparam int IN_W     = 120;
	localparam int OUT_W    = 120;

	localparam logic [LEN_W-1:0] SLOT_SIZE_RST = 25'd4096;
	localparam int SLOT_TOTAL_RST = 1024;

	localparam logic [OP_W-1:0] OP_PUT      = 2'd0;
	localparam logic [OP_W-1:0] OP_GET      = 2'd1;
	localparam logic [OP_W-1:0] OP_ERASE    = 2'd2;
	localparam logic [OP_W-1:0] OP_CONTAINS = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_SMALL = 3'd4;

	localparam logic CFG_SLOT_SIZE  = 1'b0;
	localparam logic CFG_SLOT_TOTAL = 1'b1;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_POP    = 7'b0010000,
		S_MUL    = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;
endpackage

// ----- src/ksa_ram.sv -----
module ksa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/keyed_slot_allocator_top.sv -----
// Keyed slot allocator.
// Requests enter on the s_ channel (opcode, key, put length, get capacity) and
// each produces exactly one result word on the m_ channel: status, found flag,
// slot id, byte offset, stored length and the running slot and byte totals.
// Free slot ids live on a LIFO stack in one RAM; key, length and valid flag of
// every slot live in a second RAM. A request looks up its key by reading the
// metadata RAM one entry per cycle from slot 0 up, stopping at the first hit.
// After the request word is taken, the block passes through S_SCAN, S_DECIDE,
// S_POP (only for a put that takes a free slot), S_MUL and S_RESP, where the
// result word is registered. One request is in flight at a time; s_tready is
// high only while the block is idle. After reset and after every write of
// slot_total, a clearing pass over all MAX_SLOTS entries rebuilds both RAMs;
// s_tready stays low during it.
// The result sits in an output register until taken; while m_tready is low
// the block finishes the next request's work and then waits to present it.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce this.
module keyed_slot_allocator_top #(
	parameter int MAX_SLOTS = ksa_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS  = ksa_pkg::KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ksa_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode[1:0], item_key[65:2], payload_bytes[90:66], dest_capacity[115:91]
	input  logic [ksa_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[2:0], found[3], slot_id[13:4], byte_offset[47:14],
	// stored_bytes[72:48], used_slots[83:73], used_bytes[118:84]
	output logic [ksa_pkg::OUT_W-1:0] m_tdata
);
	import ksa_pkg::*;

	localparam int SLOT_W = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int MW     = KEY_BITS + LEN_W + 1;
	localparam int TOT_RST = SLOT_TOTAL_RST > MAX_SLOTS ? MAX_SLOTS : SLOT_TOTAL_RST;

	state_t state_q;
	logic [LEN_W-1:0]    size_q;
	logic [CNT_W-1:0]    total_q, free_top_q, used_q, scan_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [SLOT_W-1:0]   clr_q, pend_idx_q, slot_q;
	logic                pend_q, hit_q, have_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LEN_W-1:0]    len_q, cap_q, hlen_q, stored_q;
	logic [STAT_W-1:0]   status_q;
	logic [SLOT_W+LEN_W-1:0] prod_q;

	logic              meta_we, stk_we;
	logic [SLOT_W-1:0] meta_waddr, meta_raddr, stk_waddr, stk_raddr;
	logic [MW-1:0]     meta_wdata, meta_rdata;
	logic [SLOT_W-1:0] stk_wdata, stk_rdata;

	logic [TOTAL_W-1:0] cfg_tot;
	logic [CNT_W-1:0]   cfg_tot_sat;
	logic               len_ok, scan_hit;

	assign cfg_tot     = cfg_data[TOTAL_W-1:0];
	assign cfg_tot_sat = (32'(cfg_tot) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_tot);
	assign len_ok      = (len_q != '0) && (len_q <= size_q);
	assign scan_hit    = pend_q && meta_rdata[MW-1] && (meta_rdata[KEY_BITS-1:0] == key_q);
	assign s_tready    = (state_q == S_IDLE);

	ksa_ram #(.WIDTH(MW), .DEPTH(MAX_SLOTS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.raddr(meta_raddr), .rdata(meta_rdata)
	);

	ksa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = hit_q ? pend_idx_q : stk_rdata;
		meta_wdata = {1'b1, len_q, key_q};
		meta_raddr = scan_q[SLOT_W-1:0];
		stk_we     = 1'b0;
		stk_waddr  = free_top_q[SLOT_W-1:0];
		stk_wdata  = pend_idx_q;
		stk_raddr  = SLOT_W'(free_top_q - CNT_W'(1));
		unique case (state_q)
			S_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = '0;
				stk_we     = 1'b1;
				stk_waddr  = clr_q;
				stk_wdata  = (CNT_W'(clr_q) < total_q) ?
					SLOT_W'(total_q - CNT_W'(clr_q) - CNT_W'(1)) : '0;
			end
			S_DECIDE: begin
				if (op_q == OP_PUT && len_ok && hit_q) begin
					meta_we = 1'b1;
				end else if (op_q == OP_ERASE && hit_q) begin
					meta_we    = 1'b1;
					meta_wdata = {1'b0, hlen_q, key_q};
					stk_we     = (32'(free_top_q) < MAX_SLOTS);
				end
			end
			S_POP: begin
				meta_we = 1'b1;
			end
			S_IDLE, S_SCAN, S_MUL, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= s_tdata[1:0];
				key_q <= s_tdata[KEY_BITS+1:2];
				len_q <= s_tdata[90:66];
				cap_q <= s_tdata[115:91];
			end
			S_SCAN: begin
				if (scan_hit) begin
					pend_idx_q <= pend_idx_q;
					hlen_q     <= meta_rdata[MW-2:KEY_BITS];
				end else begin
					pend_idx_q <= scan_q[SLOT_W-1:0];
				end
			end
			S_MUL: begin
				prod_q <= (SLOT_W+LEN_W)'(slot_q) * (SLOT_W+LEN_W)'(size_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			size_q     <= SLOT_SIZE_RST;
			total_q    <= CNT_W'(TOT_RST);
			free_top_q <= CNT_W'(TOT_RST);
			used_q     <= '0;
			bytes_q    <= '0;
			clr_q      <= '0;
			scan_q     <= '0;
			pend_q     <= 1'b0;
			hit_q      <= 1'b0;
			have_q     <= 1'b0;
			slot_q     <= '0;
			stored_q   <= '0;
			status_q   <= ST_OK;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						scan_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						hit_q   <= 1'b1;
						state_q <= S_DECIDE;
					end else if (scan_q >= total_q) begin
						hit_q   <= 1'b0;
						state_q <= S_DECIDE;
					end else begin
						pend_q <= 1'b1;
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_DECIDE: begin
					have_q   <= hit_q;
					slot_q   <= hit_q ? pend_idx_q : '0;
					stored_q <= hit_q ? hlen_q : '0;
					status_q <= ST_OK;
					state_q  <= S_MUL;
					case (op_q)
						OP_PUT: begin
							if (!len_ok) begin
								status_q <= ST_BAD_LEN;
							end else if (hit_q) begin
								bytes_q  <= bytes_q - BYTES_W'(hlen_q) + BYTES_W'(len_q);
								stored_q <= len_q;
							end else if (free_top_q == '0) begin
								status_q <= ST_FULL;
							end else begin
								free_top_q <= free_top_q - CNT_W'(1);
								state_q    <= S_POP;
							end
						end
						OP_GET: begin
							if (!hit_q) begin
								status_q <= ST_NOT_FOUND;
							end else if (cap_q < hlen_q) begin
								status_q <= ST_TOO_SMALL;
							end
						end
						OP_ERASE: begin
							if (!hit_q) begin
								status_q <= ST_NOT_FOUND;
							end else begin
								if (32'(free_top_q) < MAX_SLOTS) begin
									free_top_q <= free_top_q + CNT_W'(1);
								end
								if (used_q != '0) begin
									used_q <= used_q - CNT_W'(1);
								end
								bytes_q  <= bytes_q - BYTES_W'(hlen_q);
								stored_q <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					slot_q   <= stk_rdata;
					have_q   <= 1'b1;
					used_q   <= used_q + CNT_W'(1);
					bytes_q  <= bytes_q + BYTES_W'(len_q);
					stored_q <= len_q;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, bytes_q, USED_W'(used_q), stored_q,
							have_q ? OFF_W'(prod_q) : OFF_W'(0),
							SLOTID_W'(slot_q), hit_q, status_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (cfg_we) begin
				if (cfg_index == CFG_SLOT_SIZE) begin
					size_q <= cfg_data;
				end else begin
					total_q    <= cfg_tot_sat;
					free_top_q <= cfg_tot_sat;
					used_q     <= '0;
					bytes_q    <= '0;
					clr_q      <= '0;
					state_q    <= S_CLEAR;
				end
			end
		end
	end
endmodule

// ----- src/ksa_checker.sv -----
`include "keyed_slot_allocator_top_assert.svh"
module ksa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ksa_pkg::OUT_W-1:0] m_tdata
);
	import ksa_pkg::*;

	// A waiting result word must not change.
	`KSA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	// Status codes stay within the defined set.
	`KSA_ASSERT(a_status_range, m_tvalid |-> m_tdata[2:0] <= ST_TOO_SMALL, "undefined status code")
	// Not found and found never appear together; a too-small buffer needs a hit.
	`KSA_ASSERT(a_found_agree, m_tvalid && (m_tdata[2:0] == ST_NOT_FOUND) |-> !m_tdata[3], "not found with found set")
	`KSA_ASSERT(a_small_hit, m_tvalid && (m_tdata[2:0] == ST_TOO_SMALL) |-> m_tdata[3], "buffer check without a hit")
	// One request at a time: the block is busy right after accepting.
	`KSA_ASSERT(a_one_req, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")
endmodule

bind keyed_slot_allocator_top ksa_checker u_ksa_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
